// File: hw/rtl/rvc_instruction_expander_defines.svh
// Assertion macros shared by the compressed instruction expander.
`ifndef RVC_INSTRUCTION_EXPANDER_DEFINES_SVH
`define RVC_INSTRUCTION_EXPANDER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RVC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rvc_pkg.sv
// Opcodes, function codes and instruction builders for the RVC expander.
package rvc_pkg;

  // Compressed quadrants (low two bits of the halfword).
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Base ISA major opcodes.
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;

  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
  localparam logic [6:0]  F7_ALT      = 7'h20;
  localparam logic [6:0]  F7_BASE     = 7'h00;
  localparam logic [11:0] SRAI_MARK   = 12'h400;

  // Base ISA funct3 codes.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;

  // Compressed funct3 codes.
  localparam logic [2:0] CF3_0 = 3'd0;
  localparam logic [2:0] CF3_1 = 3'd1;
  localparam logic [2:0] CF3_2 = 3'd2;
  localparam logic [2:0] CF3_3 = 3'd3;
  localparam logic [2:0] CF3_4 = 3'd4;
  localparam logic [2:0] CF3_5 = 3'd5;
  localparam logic [2:0] CF3_6 = 3'd6;
  localparam logic [2:0] CF3_7 = 3'd7;

  // Arithmetic group selector (bits 11:10 in quadrant one, funct3 four).
  localparam logic [1:0] CA_SRLI = 2'd0;
  localparam logic [1:0] CA_SRAI = 2'd1;
  localparam logic [1:0] CA_ANDI = 2'd2;
  localparam logic [1:0] CA_REG  = 2'd3;

  // Register-register operation selector (bits 6:5).
  localparam logic [1:0] CR_SUB = 2'd0;
  localparam logic [1:0] CR_XOR = 2'd1;
  localparam logic [1:0] CR_OR  = 2'd2;
  localparam logic [1:0] CR_AND = 2'd3;

  // Fixed register numbers.
  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;
  localparam logic [4:0] REG_SP   = 5'd2;

  // R-type word.
  function automatic logic [31:0] mk_r(input logic [6:0] opc, input logic [2:0] f3,
                                       input logic [6:0] f7, input logic [4:0] rd,
                                       input logic [4:0] rs1, input logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  // I-type word.
  function automatic logic [31:0] mk_i(input logic [6:0] opc, input logic [2:0] f3,
                                       input logic [4:0] rd, input logic [4:0] rs1,
                                       input logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  // Word-sized store.
  function automatic logic [31:0] mk_s(input logic [4:0] rs1, input logic [4:0] rs2,
                                       input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, F3_WORD, imm[4:0], OPC_STORE};
  endfunction

  // Branch against x0.
  function automatic logic [31:0] mk_b(input logic [2:0] f3, input logic [4:0] rs1,
                                       input logic [12:0] imm);
    return {imm[12], imm[10:5], REG_ZERO, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  // Jump and link.
  function automatic logic [31:0] mk_j(input logic [4:0] rd, input logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

endpackage

// File: hw/rtl/rvc_decoder.sv
// Combinational expansion of one compressed halfword into a base ISA word.
module rvc_decoder (
  input  logic [15:0] cword,
  output logic [31:0] word,
  output logic        illegal
);

  logic [1:0]  quad;
  logic [2:0]  cf3;
  logic [4:0]  rd;
  logic [4:0]  rs2;
  logic [4:0]  rdp;
  logic [4:0]  rsp;
  logic        b12;
  logic [5:0]  imm6;
  logic [11:0] imm6_sx;
  logic [20:0] jimm;
  logic [12:0] bimm;
  logic [9:0]  spn_imm;
  logic [9:0]  sp16_imm;
  logic [6:0]  lw_imm;
  logic [7:0]  lwsp_imm;
  logic [7:0]  swsp_imm;

  // Field extraction and immediate scatter.
  assign quad     = cword[1:0];
  assign cf3      = cword[15:13];
  assign rd       = cword[11:7];
  assign rs2      = cword[6:2];
  assign rdp      = {2'b01, cword[9:7]};
  assign rsp      = {2'b01, cword[4:2]};
  assign b12      = cword[12];
  assign imm6     = {cword[12], cword[6:2]};
  assign imm6_sx  = {{6{cword[12]}}, imm6};
  assign jimm     = {{9{cword[12]}}, cword[12], cword[8], cword[10:9], cword[6], cword[7],
                     cword[2], cword[11], cword[5:3], 1'b0};
  assign bimm     = {{4{cword[12]}}, cword[12], cword[6:5], cword[2], cword[11:10],
                     cword[4:3], 1'b0};
  assign spn_imm  = {cword[10:7], cword[12:11], cword[5], cword[6], 2'b00};
  assign sp16_imm = {cword[12], cword[4:3], cword[5], cword[2], cword[6], 4'b0000};
  assign lw_imm   = {cword[5], cword[12:10], cword[6], 2'b00};
  assign lwsp_imm = {cword[3:2], cword[12], cword[6:4], 2'b00};
  assign swsp_imm = {cword[8:7], cword[12:9], 2'b00};

  // Expansion; every reserved or unsupported encoding yields a zero word.
  always_comb begin
    word = '0;
    case (quad)
      rvc_pkg::QUAD_0: begin
        case (cf3)
          rvc_pkg::CF3_0: begin
            if (spn_imm != '0) begin
              word = rvc_pkg::mk_i(rvc_pkg::OPC_OPIMM, rvc_pkg::F3_ADD, rsp,
                                   rvc_pkg::REG_SP, {2'b00, spn_imm});
            end
          end
          rvc_pkg::CF3_2: begin
            word = rvc_pkg::mk_i(rvc_pkg::OPC_LOAD, rvc_pkg::F3_WORD, rsp, rdp,
                                 {5'b00000, lw_imm});
          end
          rvc_pkg::CF3_6: begin
            word = rvc_pkg::mk_s(rdp, rsp, {5'b00000, lw_imm});
          end
          default: word = '0;
        endcase
      end
      rvc_pkg::QUAD_1: begin
        case (cf3)
          rvc_pkg::CF3_0: begin
            word = rvc_pkg::mk_i(rvc_pkg::OPC_OPIMM, rvc_pkg::F3_ADD, rd, rd, imm6_sx);
          end
          rvc_pkg::CF3_1: begin
            word = rvc_pkg::mk_j(rvc_pkg::REG_RA, jimm);
          end
          rvc_pkg::CF3_2: begin
            if (rd != rvc_pkg::REG_ZERO) begin
              word = rvc_pkg::mk_i(rvc_pkg::OPC_OPIMM, rvc_pkg::F3_ADD, rd,
                                   rvc_pkg::REG_ZERO, imm6_sx);
            end
          end
          rvc_pkg::CF3_3: begin
            // Stack pointer adjust when rd is sp, upper immediate otherwise.
            if (rd == rvc_pkg::REG_SP) begin
              if (sp16_imm != '0) begin
                word = rvc_pkg::mk_i(rvc_pkg::OPC_OPIMM, rvc_pkg::F3_ADD, rvc_pkg::REG_SP,
                                     rvc_pkg::REG_SP, {{2{cword[12]}}, sp16_imm});
              end
            end else if (rd != rvc_pkg::REG_ZERO && imm6 != '0) begin
              word = {{14{cword[12]}}, imm6, rd, rvc_pkg::OPC_LUI};
            end
          end
          rvc_pkg::CF3_4: begin
            case (cword[11:10])
              rvc_pkg::CA_SRLI: begin
                if (!b12) begin
                  word = rvc_pkg::mk_i(rvc_pkg::OPC_OPIMM, rvc_pkg::F3_SR, rdp, rdp,
                                       {6'b000000, imm6});
                end
              end
              rvc_pkg::CA_SRAI: begin
                if (!b12) begin
                  word = rvc_pkg::mk_i(rvc_pkg::OPC_OPIMM, rvc_pkg::F3_SR, rdp, rdp,
                                       {6'b000000, imm6} | rvc_pkg::SRAI_MARK);
                end
              end
              rvc_pkg::CA_ANDI: begin
                word = rvc_pkg::mk_i(rvc_pkg::OPC_OPIMM, rvc_pkg::F3_AND, rdp, rdp, imm6_sx);
              end
              rvc_pkg::CA_REG: begin
                if (!b12) begin
                  case (cword[6:5])
                    rvc_pkg::CR_SUB: word = rvc_pkg::mk_r(rvc_pkg::OPC_OP, rvc_pkg::F3_ADD,
                                                          rvc_pkg::F7_ALT, rdp, rdp, rsp);
                    rvc_pkg::CR_XOR: word = rvc_pkg::mk_r(rvc_pkg::OPC_OP, rvc_pkg::F3_XOR,
                                                          rvc_pkg::F7_BASE, rdp, rdp, rsp);
                    rvc_pkg::CR_OR:  word = rvc_pkg::mk_r(rvc_pkg::OPC_OP, rvc_pkg::F3_OR,
                                                          rvc_pkg::F7_BASE, rdp, rdp, rsp);
                    rvc_pkg::CR_AND: word = rvc_pkg::mk_r(rvc_pkg::OPC_OP, rvc_pkg::F3_AND,
                                                          rvc_pkg::F7_BASE, rdp, rdp, rsp);
                    default: word = '0;
                  endcase
                end
              end
              default: word = '0;
            endcase
          end
          rvc_pkg::CF3_5: begin
            word = rvc_pkg::mk_j(rvc_pkg::REG_ZERO, jimm);
          end
          default: begin
            word = rvc_pkg::mk_b((cf3 == rvc_pkg::CF3_6) ? rvc_pkg::F3_BEQ : rvc_pkg::F3_BNE,
                                 rdp, bimm);
          end
        endcase
      end
      rvc_pkg::QUAD_2: begin
        case (cf3)
          rvc_pkg::CF3_0: begin
            if (rd != rvc_pkg::REG_ZERO && imm6 != '0 && !b12) begin
              word = rvc_pkg::mk_i(rvc_pkg::OPC_OPIMM, rvc_pkg::F3_SLL, rd, rd,
                                   {6'b000000, imm6});
            end
          end
          rvc_pkg::CF3_2: begin
            if (rd != rvc_pkg::REG_ZERO) begin
              word = rvc_pkg::mk_i(rvc_pkg::OPC_LOAD, rvc_pkg::F3_WORD, rd, rvc_pkg::REG_SP,
                                   {4'b0000, lwsp_imm});
            end
          end
          rvc_pkg::CF3_4: begin
            // Jump register, move, breakpoint, jump and link register, add.
            if (!b12) begin
              if (rd != rvc_pkg::REG_ZERO) begin
                if (rs2 == rvc_pkg::REG_ZERO) begin
                  word = rvc_pkg::mk_i(rvc_pkg::OPC_JALR, rvc_pkg::F3_ADD, rvc_pkg::REG_ZERO,
                                       rd, 12'd0);
                end else begin
                  word = rvc_pkg::mk_r(rvc_pkg::OPC_OP, rvc_pkg::F3_ADD, rvc_pkg::F7_BASE, rd,
                                       rvc_pkg::REG_ZERO, rs2);
                end
              end
            end else if (rd == rvc_pkg::REG_ZERO) begin
              if (rs2 == rvc_pkg::REG_ZERO) begin
                word = rvc_pkg::WORD_EBREAK;
              end
            end else if (rs2 == rvc_pkg::REG_ZERO) begin
              word = rvc_pkg::mk_i(rvc_pkg::OPC_JALR, rvc_pkg::F3_ADD, rvc_pkg::REG_RA,
                                   rd, 12'd0);
            end else begin
              word = rvc_pkg::mk_r(rvc_pkg::OPC_OP, rvc_pkg::F3_ADD, rvc_pkg::F7_BASE, rd, rd,
                                   rs2);
            end
          end
          rvc_pkg::CF3_6: begin
            word = rvc_pkg::mk_s(rvc_pkg::REG_SP, rs2, {4'b0000, swsp_imm});
          end
          default: word = '0;
        endcase
      end
      default: word = '0;
    endcase
  end

  // A zero word is never a legal expansion, so it marks the illegal case.
  assign illegal = (word == '0);

endmodule

// File: hw/rtl/rvc_instruction_expander.sv
// Top level of the compressed instruction expander: input register, decoder, result register.
// The expander takes one compressed halfword per cycle whenever start is high; busy
// stays low, so an item can be issued every cycle. Each item's result reaches the out_
// ports through the input register, then the decode logic feeding the result register,
// marked by a one-cycle out_valid strobe. Results cannot be held off, so the receiver
// must take each one as it comes.
// An all-zero, reserved or unsupported halfword gives an expanded word of zero with
// out_illegal set.
`include "rvc_instruction_expander_defines.svh"

module rvc_instruction_expander (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_compressed_word,
  output logic        out_valid,
  output logic [31:0] out_expanded_word,
  output logic        out_illegal
);

  logic        accept;
  logic        in_valid_r;
  logic [15:0] in_word_r;
  logic [31:0] dec_word;
  logic        dec_illegal;
  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic        out_illegal_r;

  // The pipeline never stalls, so an item is taken on every start.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= accept;
      out_valid_r <= in_valid_r;
    end
  end

  // Input register captures the halfword of an accepted item.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_word_r <= in_compressed_word;
    end
  end

  rvc_decoder u_decoder (
    .cword   (in_word_r),
    .word    (dec_word),
    .illegal (dec_illegal)
  );

  // Result register holds the expanded word for its one-cycle strobe.
  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_word_r    <= dec_word;
      out_illegal_r <= dec_illegal;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_expanded_word = out_word_r;
  assign out_illegal       = out_illegal_r;

  // Every accepted item moves through both stages without a gap.
  `RVC_ASSERT_NEXT(a_in_stage, accept, in_valid_r, "accepted item did not reach input stage")
  `RVC_ASSERT_NEXT(a_out_stage, in_valid_r, out_valid, "item dropped between stages")
  // The illegal flag and the zero word always agree.
  `RVC_ASSERT_NOW(a_illegal_zero, out_valid, out_illegal == (out_expanded_word == '0),
                  "illegal flag disagrees with expanded word")
  // A full-width instruction in the input stage is reported as illegal.
  `RVC_ASSERT_NEXT(a_quad3, in_valid_r && in_word_r[1:0] == rvc_pkg::QUAD_3, out_illegal,
                   "uncompressed encoding not flagged illegal")

endmodule

// File: test/rvc_instruction_expander_tb.sv
// Self-checking testbench for the compressed instruction expander: directed table, then bursts.
module rvc_instruction_expander_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 2000;
  localparam int IDLE_LIMIT   = 200;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [31:0] word;
    logic        illegal;
  } expansion_t;

  typedef struct packed {
    logic [15:0] halfword;
    logic        known;
    logic [31:0] word;
    logic        illegal;
  } directed_row_t;

  // Directed rows: known results are typed in, the rest go through the predictor.
  localparam int N_DIRECTED = 37;
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{16'h0000, 1'b1, 32'h0000_0000, 1'b1},  // all-zero halfword
    '{16'hFFFF, 1'b1, 32'h0000_0000, 1'b1},  // quadrant three
    '{16'h0004, 1'b1, 32'h0000_0000, 1'b1},  // C.ADDI4SPN with zero immediate
    '{16'h6101, 1'b1, 32'h0000_0000, 1'b1},  // C.ADDI16SP with zero immediate
    '{16'h6081, 1'b1, 32'h0000_0000, 1'b1},  // C.LUI with zero immediate
    '{16'h1086, 1'b1, 32'h0000_0000, 1'b1},  // C.SLLI with shift bit five set
    '{16'h4002, 1'b1, 32'h0000_0000, 1'b1},  // C.LWSP to x0
    '{16'h8002, 1'b1, 32'h0000_0000, 1'b1},  // C.JR through x0
    '{16'h9C01, 1'b1, 32'h0000_0000, 1'b1},  // RV64 word form of the ALU group
    '{16'h2000, 1'b1, 32'h0000_0000, 1'b1},  // floating-point load
    '{16'h0001, 1'b1, 32'h0000_0013, 1'b0},  // C.NOP
    '{16'h9002, 1'b1, rvc_pkg::WORD_EBREAK, 1'b0},  // C.EBREAK
    '{16'h1FFC, 1'b0, 32'h0, 1'b0},  // C.ADDI4SPN, largest immediate
    '{16'h4000, 1'b0, 32'h0, 1'b0},  // C.LW, zero offset
    '{16'hDFFC, 1'b0, 32'h0, 1'b0},  // C.SW, largest offset
    '{16'h1FFD, 1'b0, 32'h0, 1'b0},  // C.ADDI, negative immediate
    '{16'h3FFD, 1'b0, 32'h0, 1'b0},  // C.JAL
    '{16'h5FFD, 1'b0, 32'h0, 1'b0},  // C.LI
    '{16'h717D, 1'b0, 32'h0, 1'b0},  // C.ADDI16SP
    '{16'h7FFD, 1'b0, 32'h0, 1'b0},  // C.LUI
    '{16'h8001, 1'b0, 32'h0, 1'b0},  // C.SRLI by zero
    '{16'h847D, 1'b0, 32'h0, 1'b0},  // C.SRAI
    '{16'h9BFD, 1'b0, 32'h0, 1'b0},  // C.ANDI
    '{16'h8C01, 1'b0, 32'h0, 1'b0},  // C.SUB
    '{16'h8C21, 1'b0, 32'h0, 1'b0},  // C.XOR
    '{16'h8C41, 1'b0, 32'h0, 1'b0},  // C.OR
    '{16'h8C61, 1'b0, 32'h0, 1'b0},  // C.AND
    '{16'hBFFD, 1'b0, 32'h0, 1'b0},  // C.J
    '{16'hDFFD, 1'b0, 32'h0, 1'b0},  // C.BEQZ
    '{16'hFFFD, 1'b0, 32'h0, 1'b0},  // C.BNEZ
    '{16'h0FFE, 1'b0, 32'h0, 1'b0},  // C.SLLI
    '{16'h5FFE, 1'b0, 32'h0, 1'b0},  // C.LWSP
    '{16'h8F82, 1'b0, 32'h0, 1'b0},  // C.JR
    '{16'h8FFE, 1'b0, 32'h0, 1'b0},  // C.MV
    '{16'h9F82, 1'b0, 32'h0, 1'b0},  // C.JALR
    '{16'h9FFE, 1'b0, 32'h0, 1'b0},  // C.ADD
    '{16'hDFFE, 1'b0, 32'h0, 1'b0}   // C.SWSP
  };

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_compressed_word;
  logic        out_valid;
  logic [31:0] out_expanded_word;
  logic        out_illegal;

  // Typed expectation that travels with the item currently on the input.
  logic        pending_known;
  expansion_t  pending_typed;

  expansion_t  pending_expansions [$];
  int          mismatch_count;
  int          idle_cycles;

  rvc_instruction_expander u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_compressed_word(in_compressed_word),
    .out_valid         (out_valid),
    .out_expanded_word (out_expanded_word),
    .out_illegal       (out_illegal)
  );

  always #5 clk = ~clk;

  // I-type, R-type, store-word and JAL encodings; the branch and LUI builders are inline.
  function automatic logic [31:0] encode_i(input logic [6:0] opc, input logic [2:0] f3,
                                           input logic [4:0] rd, input logic [4:0] rs1,
                                           input logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] encode_r(input logic [6:0] opc, input logic [2:0] f3,
                                           input logic [6:0] f7, input logic [4:0] rd,
                                           input logic [4:0] rs1, input logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] encode_sw(input logic [4:0] rs1, input logic [4:0] rs2,
                                            input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, rvc_pkg::F3_WORD, imm[4:0], rvc_pkg::OPC_STORE};
  endfunction

  function automatic logic [31:0] encode_jal(input logic [4:0] rd, input logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rvc_pkg::OPC_JAL};
  endfunction

  // Predicts the expanded instruction of one halfword.
  function automatic expansion_t expand_halfword(input logic [15:0] c);
    logic [4:0]  rd;
    logic [4:0]  rs2;
    logic [4:0]  rdp;
    logic [4:0]  rsp;
    logic        b12;
    logic [5:0]  imm6;
    logic [11:0] imm6_sx;
    logic [9:0]  spn_imm;
    logic [6:0]  word_off;
    logic [7:0]  sp_off;
    logic [9:0]  sp_adj;
    logic [11:0] jump_off;
    logic [20:0] jump_sx;
    logic [8:0]  br_off;
    logic [12:0] br_sx;
    logic [31:0] w;
    expansion_t  res;
    rd       = c[11:7];
    rs2      = c[6:2];
    rdp      = {2'b01, c[9:7]};
    rsp      = {2'b01, c[4:2]};
    b12      = c[12];
    imm6     = {c[12], c[6:2]};
    imm6_sx  = {{6{imm6[5]}}, imm6};
    spn_imm  = {c[10:7], c[12:11], c[5], c[6], 2'b00};
    word_off = {c[5], c[12:10], c[6], 2'b00};
    jump_off = {c[12], c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
    jump_sx  = {{9{jump_off[11]}}, jump_off};
    br_off   = {c[12], c[6:5], c[2], c[11:10], c[4:3], 1'b0};
    br_sx    = {{4{br_off[8]}}, br_off};
    sp_adj   = {c[12], c[4:3], c[5], c[2], c[6], 4'b0000};
    w = '0;
    case (c[1:0])
      rvc_pkg::QUAD_0: begin
        case (c[15:13])
          rvc_pkg::CF3_0: begin
            if (spn_imm != '0)
              w = encode_i(rvc_pkg::OPC_OPIMM, rvc_pkg::F3_ADD, rsp, rvc_pkg::REG_SP,
                           {2'b00, spn_imm});
          end
          rvc_pkg::CF3_2: w = encode_i(rvc_pkg::OPC_LOAD, rvc_pkg::F3_WORD, rsp, rdp,
                                       {5'b0, word_off});
          rvc_pkg::CF3_6: w = encode_sw(rdp, rsp, {5'b0, word_off});
          default: w = '0;
        endcase
      end
      rvc_pkg::QUAD_1: begin
        case (c[15:13])
          rvc_pkg::CF3_0: w = encode_i(rvc_pkg::OPC_OPIMM, rvc_pkg::F3_ADD, rd, rd, imm6_sx);
          rvc_pkg::CF3_1: w = encode_jal(rvc_pkg::REG_RA, jump_sx);
          rvc_pkg::CF3_2: begin
            if (rd != rvc_pkg::REG_ZERO)
              w = encode_i(rvc_pkg::OPC_OPIMM, rvc_pkg::F3_ADD, rd, rvc_pkg::REG_ZERO, imm6_sx);
          end
          rvc_pkg::CF3_3: begin
            // Destination sp selects C.ADDI16SP, anything else is C.LUI.
            if (rd == rvc_pkg::REG_SP) begin
              if (sp_adj != '0)
                w = encode_i(rvc_pkg::OPC_OPIMM, rvc_pkg::F3_ADD, rvc_pkg::REG_SP,
                             rvc_pkg::REG_SP, {{2{sp_adj[9]}}, sp_adj});
            end else if (rd != rvc_pkg::REG_ZERO && imm6 != '0) begin
              w = {{14{imm6[5]}}, imm6, rd, rvc_pkg::OPC_LUI};
            end
          end
          rvc_pkg::CF3_4: begin
            case (c[11:10])
              rvc_pkg::CA_SRLI: begin
                if (!b12)
                  w = encode_i(rvc_pkg::OPC_OPIMM, rvc_pkg::F3_SR, rdp, rdp, {6'b0, imm6});
              end
              rvc_pkg::CA_SRAI: begin
                if (!b12)
                  w = encode_i(rvc_pkg::OPC_OPIMM, rvc_pkg::F3_SR, rdp, rdp,
                               {6'b0, imm6} | rvc_pkg::SRAI_MARK);
              end
              rvc_pkg::CA_ANDI: w = encode_i(rvc_pkg::OPC_OPIMM, rvc_pkg::F3_AND, rdp, rdp,
                                             imm6_sx);
              rvc_pkg::CA_REG: begin
                if (!b12) begin
                  case (c[6:5])
                    rvc_pkg::CR_SUB: w = encode_r(rvc_pkg::OPC_OP, rvc_pkg::F3_ADD,
                                                  rvc_pkg::F7_ALT, rdp, rdp, rsp);
                    rvc_pkg::CR_XOR: w = encode_r(rvc_pkg::OPC_OP, rvc_pkg::F3_XOR,
                                                  rvc_pkg::F7_BASE, rdp, rdp, rsp);
                    rvc_pkg::CR_OR:  w = encode_r(rvc_pkg::OPC_OP, rvc_pkg::F3_OR,
                                                  rvc_pkg::F7_BASE, rdp, rdp, rsp);
                    rvc_pkg::CR_AND: w = encode_r(rvc_pkg::OPC_OP, rvc_pkg::F3_AND,
                                                  rvc_pkg::F7_BASE, rdp, rdp, rsp);
                    default: w = '0;
                  endcase
                end
              end
              default: w = '0;
            endcase
          end
          rvc_pkg::CF3_5: w = encode_jal(rvc_pkg::REG_ZERO, jump_sx);
          default: begin
            w = {br_sx[12], br_sx[10:5], rvc_pkg::REG_ZERO, rdp,
                 (c[15:13] == rvc_pkg::CF3_6) ? rvc_pkg::F3_BEQ : rvc_pkg::F3_BNE,
                 br_sx[4:1], br_sx[11], rvc_pkg::OPC_BRANCH};
          end
        endcase
      end
      rvc_pkg::QUAD_2: begin
        case (c[15:13])
          rvc_pkg::CF3_0: begin
            if (rd != rvc_pkg::REG_ZERO && imm6 != '0 && !b12)
              w = encode_i(rvc_pkg::OPC_OPIMM, rvc_pkg::F3_SLL, rd, rd, {6'b0, imm6});
          end
          rvc_pkg::CF3_2: begin
            sp_off = {c[3:2], c[12], c[6:4], 2'b00};
            if (rd != rvc_pkg::REG_ZERO)
              w = encode_i(rvc_pkg::OPC_LOAD, rvc_pkg::F3_WORD, rd, rvc_pkg::REG_SP,
                           {4'b0, sp_off});
          end
          rvc_pkg::CF3_4: begin
            // Jumps through a register, moves, adds and the breakpoint.
            if (!b12) begin
              if (rd != rvc_pkg::REG_ZERO)
                w = (rs2 == rvc_pkg::REG_ZERO)
                    ? encode_i(rvc_pkg::OPC_JALR, rvc_pkg::F3_ADD, rvc_pkg::REG_ZERO, rd, '0)
                    : encode_r(rvc_pkg::OPC_OP, rvc_pkg::F3_ADD, rvc_pkg::F7_BASE, rd,
                               rvc_pkg::REG_ZERO, rs2);
            end else if (rd == rvc_pkg::REG_ZERO) begin
              if (rs2 == rvc_pkg::REG_ZERO) w = rvc_pkg::WORD_EBREAK;
            end else begin
              w = (rs2 == rvc_pkg::REG_ZERO)
                  ? encode_i(rvc_pkg::OPC_JALR, rvc_pkg::F3_ADD, rvc_pkg::REG_RA, rd, '0)
                  : encode_r(rvc_pkg::OPC_OP, rvc_pkg::F3_ADD, rvc_pkg::F7_BASE, rd, rd, rs2);
            end
          end
          rvc_pkg::CF3_6: begin
            sp_off = {c[8:7], c[12:9], 2'b00};
            w = encode_sw(rvc_pkg::REG_SP, rs2, {4'b0, sp_off});
          end
          default: w = '0;
        endcase
      end
      default: w = '0;
    endcase
    res.word    = w;
    res.illegal = (w == '0);
    return res;
  endfunction

  // Random halfword, mostly compressed and often with zeroed register or immediate fields.
  function automatic logic [15:0] make_halfword();
    logic [15:0] hw;
    hw = 16'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 7) != 0) hw[1:0] = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) hw[11:7] = '0;
      if ($urandom_range(0, 3) == 0) hw[6:2] = '0;
      if ($urandom_range(0, 3) == 0) hw[12] = 1'b0;
      if ($urandom_range(0, 7) == 0) hw[11:7] = rvc_pkg::REG_SP;
    end
    return hw;
  endfunction

  // Offers one item and returns at the edge that accepts it.
  task automatic offer_item(input logic [15:0] hw, input logic known, input expansion_t typed);
    start              <= 1'b1;
    in_compressed_word <= hw;
    pending_known      <= known;
    pending_typed      <= typed;
    do @(posedge clk); while (busy);
  endtask

  // Holds the input off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_expansions.size() != 0) @(posedge clk);
  endtask

  // Scoreboard: checks each strobed result, then records the item taken at this edge.
  always @(posedge clk) begin
    expansion_t want;
    if (rst_n) begin
      if (out_valid || (start && !busy)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (out_valid) begin
        if (pending_expansions.size() == 0) begin
          $error("unexpected result: expanded_word %h illegal %b", out_expanded_word, out_illegal);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = pending_expansions.pop_front();
          if (out_expanded_word !== want.word) begin
            $error("expanded_word: expected %h, actual %h", want.word, out_expanded_word);
            mismatch_count = mismatch_count + 1;
          end
          if (out_illegal !== want.illegal) begin
            $error("illegal: expected %b, actual %b", want.illegal, out_illegal);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if (start && !busy)
        pending_expansions.push_back(pending_known ? pending_typed
                                                   : expand_halfword(in_compressed_word));
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[rvc_instruction_expander] ERROR");
        $finish;
      end
    end
  end

  initial begin
    expansion_t typed;
    int sent;
    int burst;
    int gap;
    clk                = 1'b0;
    rst_n              = 1'b0;
    start              = 1'b0;
    in_compressed_word = '0;
    pending_known      = 1'b0;
    pending_typed      = '0;
    mismatch_count     = 0;
    idle_cycles        = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, back to back.
    foreach (directed_rows[i]) begin
      typed.word    = directed_rows[i].word;
      typed.illegal = directed_rows[i].illegal;
      offer_item(directed_rows[i].halfword, directed_rows[i].known, typed);
    end
    drain_results();

    // Random bursts with random gaps; one full drain halfway through.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 16);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        offer_item(make_halfword(), 1'b0, '0);
        sent = sent + 1;
        if (sent == RANDOM_ITEMS / 2) drain_results();
      end
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 10);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_expansions.size() == 0) begin
      $display("[rvc_instruction_expander] OK");
    end else begin
      $display("[rvc_instruction_expander] ERROR");
    end
    $finish;
  end

endmodule
